// ----- design/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map, indexed by word address
  localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkv_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } lkv_state_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic scan;
    logic apply;
    logic out_load;
  } lkv_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic scan_done;
    logic op_put;
    logic found;
    logic out_free;
  } lkv_status_t;

endpackage

// ----- design/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: configuration port, controller and datapath.
//
// Usage
//   Input stream (s_*): one word per operation. s_tuser is the operation
//   (0 get, 1 put); s_tdata holds key in [31:0] and value in [63:32].
//   Output stream (m_*): one word per get. m_tuser is the hit flag; m_tdata
//   is the stored value on a hit and zero on a miss. Puts give no word.
//   Configuration: register 0 at byte address 0 is capacity (5 bits); zero
//   acts as one, values above CAPACITY act as CAPACITY. Write while idle.
// Timing
//   Every entry's key is read from the key store one per cycle. An
//   operation is taken, scanned over every entry and then applied; a get
//   next waits until the output register is free and loads its result.
//   s_tready is high only between operations.
// Reset and stalls
//   Reset empties the cache at once (valid bits cleared, no clearing pass)
//   and sets capacity to 16. A stalled output word holds in its register;
//   the next operation is still taken and runs, and only a get waits for
//   the register to drain before its result is loaded.
module lru_key_value_cache #(
  parameter int CAPACITY = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // APB configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [lkv_pkg::PADDR_W-1:0]               paddr,
  input  logic [lkv_pkg::PDATA_W-1:0]               pwdata,
  output logic [lkv_pkg::PDATA_W-1:0]               prdata,
  output logic                                      pready,
  // Input stream
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]  s_tdata,  // key, value
  input  logic                                      s_tuser,  // op
  // Output stream
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [lkv_pkg::VAL_W-1:0]                 m_tdata,  // read_value
  output logic                                      m_tuser   // hit
);
  import lkv_pkg::*;

  logic [CFG_W-1:0] capacity;
  lkv_cmd_t         cmd;
  lkv_status_t      status;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(capacity) : '0;

  lkv_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lkv_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .capacity (capacity),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  assign s_tready = cmd.in_ready;

  // An accepted word always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> cmd.scan)
    else $error("accepted word did not start a scan");

  // Controller phases never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.in_ready, cmd.scan, cmd.apply, cmd.out_load}))
    else $error("controller phases overlap");

  // Scan completes only while scanning
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    status.scan_done |-> cmd.scan)
    else $error("scan done outside scan phase");

  // A loaded result is offered on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not offered");

endmodule

// ----- design/lkv_ctrl.sv -----
// Controller state machine for the LRU key-value cache.
module lkv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  lkv_pkg::lkv_status_t status,
  output lkv_pkg::lkv_cmd_t    cmd
);
  import lkv_pkg::*;

  lkv_state_t state;
  lkv_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through scan, apply and response
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        // Leave idle only when a word is actually taken
        if (status.in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (status.op_put) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        cmd.out_load = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lkv_datapath.sv -----
// Datapath of the LRU key-value cache: stores, rank cells, scan and output register.
module lkv_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  lkv_pkg::lkv_cmd_t                         cmd,
  output lkv_pkg::lkv_status_t                      status,
  input  logic [lkv_pkg::CFG_W-1:0]                 capacity,
  input  logic                                      s_tvalid,
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]  s_tdata,
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [lkv_pkg::VAL_W-1:0]                 m_tdata,
  output logic                                      m_tuser
);
  import lkv_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(CAPACITY);

  // Stores
  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];

  // Rank cells
  logic [CAPACITY-1:0] valid_bits;
  logic [IDX_W-1:0]    rank [CAPACITY];
  logic [CNT_W-1:0]    entry_count;

  // Current word
  lkv_op_t          op_reg;
  logic [KEY_W-1:0] key_reg;
  logic [VAL_W-1:0] val_reg;

  // Scan pipeline
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] idx_q;
  logic             cmp_en_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Scan results
  logic             found;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] victim_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             load;
  logic             cmp_act;
  logic             cur_valid;
  logic [IDX_W-1:0] cur_rank;
  logic [IDX_W-1:0] count_m1;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             evict;
  logic [IDX_W-1:0] target;
  logic             touch;
  logic             put_new;
  logic             put_any;

  assign load      = s_tvalid && cmd.in_ready;
  assign cmp_act   = cmd.scan && cmp_en_q;
  assign cur_valid = valid_bits[idx_q];
  assign cur_rank  = rank[idx_q];
  assign count_m1  = IDX_W'(entry_count - CNT_W'(1));

  // Clip the capacity register to a usable size
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Pick the slot to write: present key, else victim or first free entry
  always_comb begin
    evict = CMP_W'(entry_count) >= eff_cap;
    if (found) begin
      target = slot;
    end else if (evict && (!free_found || victim_idx < free_idx)) begin
      target = victim_idx;
    end else begin
      target = free_idx;
    end
  end

  assign put_any = cmd.apply && (op_reg == OP_PUT);
  assign put_new = put_any && !found;
  assign touch   = cmd.apply && found;

  // Latch the incoming word
  always_ff @(posedge clk) begin
    if (load) begin
      op_reg  <= lkv_op_t'(s_tuser);
      key_reg <= s_tdata[KEY_W-1:0];
      val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  // Step the scan index and delay it alongside the key read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd.scan;
      if (load) begin
        scan_idx <= '0;
      end else if (cmd.scan) begin
        scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + IDX_W'(1);
      end
    end
    idx_q <= scan_idx;
  end

  // Key and value stores, registered reads
  always_ff @(posedge clk) begin
    if (put_new) begin
      key_mem[target] <= key_reg;
    end
    key_q <= key_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (put_any) begin
      val_mem[target] <= val_reg;
    end
    val_q <= val_mem[slot];
  end

  // Collect hit, victim and first free entry over the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_act) begin
      if (cur_valid && key_q == key_reg && !found) begin
        found <= 1'b1;
      end
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_act) begin
      if (cur_valid && key_q == key_reg && !found) begin
        slot     <= idx_q;
        hit_rank <= cur_rank;
      end
      if (cur_valid && cur_rank == count_m1) begin
        victim_idx <= idx_q;
      end
      if (!cur_valid && !free_found) begin
        free_idx <= idx_q;
      end
    end
  end

  // Update recency ranks and valid bits in every cell at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (touch) begin
          if (IDX_W'(i) == slot) begin
            rank[i] <= '0;
          end else if (valid_bits[i] && rank[i] < hit_rank) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end else if (put_new) begin
          if (IDX_W'(i) == target) begin
            valid_bits[i] <= 1'b1;
            rank[i]       <= '0;
          end else if (evict && IDX_W'(i) == victim_idx) begin
            valid_bits[i] <= 1'b0;
            rank[i]       <= '0;
          end else if (valid_bits[i]) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  // Grow the fill only when nothing is evicted
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (put_new && !evict) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= found;
      m_tdata <= found ? val_q : '0;
    end
  end

  assign status.in_valid  = s_tvalid;
  assign status.scan_done = cmp_act && (idx_q == LAST_IDX);
  assign status.op_put    = (op_reg == OP_PUT);
  assign status.found     = found;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule
